/* design/lss_pkg.sv */
// ----------------------------------------------------------------------------
// LIFO stack with search: shared package
// Field widths, storage geometry, operation codes and the payload structs of
// both channels.
// ----------------------------------------------------------------------------
package lss_pkg;

    // storage geometry
    localparam int DEPTH  = 64;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);

    // payload field widths
    localparam int FUNC_W      = 2;
    localparam int WORD_W      = 32;
    localparam int POS_W       = 6;
    localparam int DEPTH_NOW_W = 7;

    // common width for count, position and depth arithmetic
    localparam int WIDE_W = (CNT_W > DEPTH_NOW_W) ? CNT_W : DEPTH_NOW_W;

    // operation codes
    localparam logic [FUNC_W-1:0] OP_PUSH = 2'd0;
    localparam logic [FUNC_W-1:0] OP_POP  = 2'd1;
    localparam logic [FUNC_W-1:0] OP_FIND = 2'd2;
    localparam logic [FUNC_W-1:0] OP_READ = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [WORD_W-1:0] value;
        logic [POS_W-1:0]         position_in;
    } in_t;

    typedef struct packed {
        logic                     ok;
        logic signed [WORD_W-1:0] data_out;
        logic [POS_W-1:0]         found_position;
        logic [DEPTH_NOW_W-1:0]   depth_now;
        logic                     is_empty;
    } out_t;

endpackage

/* design/lss_ram.sv */
// ----------------------------------------------------------------------------
// LIFO stack with search: word store
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lss_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 6,
    parameter int WORDS  = 64
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [WORDS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* design/lifo_stack_with_search_top.sv */
// ----------------------------------------------------------------------------
// LIFO stack with search: top level
// Push, pop, find-value and read-at-position on a RAM-held word stack.
// ----------------------------------------------------------------------------
// Sequence: push and operations that fail at once go straight to EMIT, pop
//   and read pass through READ, find scans down from the top to a match or the bottom.
// Throughput: one item at a time; a find scan reads one word per cycle, and a
//   held result stalls input.
// Reset: aresetn synchronous, active low; empties the stack and drops any
//   pending result. RAM contents are not cleared.
// ----------------------------------------------------------------------------
module lifo_stack_with_search_top (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  lss_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output lss_pkg::out_t m_data
);
    import lss_pkg::*;

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;  // wait for an input transfer
    localparam logic [1:0] ST_READ = 2'd1;  // RAM word for pop/read is back
    localparam logic [1:0] ST_SCAN = 2'd2;  // find: compare one word a cycle
    localparam logic [1:0] ST_EMIT = 2'd3;  // move result into output register

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [WORD_W-1:0] value_reg, value_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;   // RAM address of current scan word
    logic [ADDR_W-1:0] d_reg, d_next;         // scan depth from top
    out_t              res_reg, res_next;
    out_t              m_data_reg, m_data_next;
    logic              m_valid_reg, m_valid_next;

    // RAM port signals
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [WORD_W-1:0] rd_data;

    // widened copies for compare and depth arithmetic
    logic [WIDE_W-1:0] cnt_wide;
    logic [WIDE_W-1:0] pos_wide;
    logic [WIDE_W-1:0] d_wide;
    logic [WIDE_W-1:0] top_wide;    // count - 1
    logic [WIDE_W-1:0] rd_at_wide;  // count - 1 - position
    logic              out_free;
    logic              scan_last;

    lss_ram #(
        .DATA_W (WORD_W),
        .ADDR_W (ADDR_W),
        .WORDS  (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // output register is free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_ready;

    assign cnt_wide   = WIDE_W'(count_reg);
    assign pos_wide   = WIDE_W'(s_data.position_in);
    assign d_wide     = WIDE_W'(d_reg);
    assign top_wide   = cnt_wide - WIDE_W'(1);
    assign rd_at_wide = top_wide - pos_wide;
    assign scan_last  = (d_wide == top_wide);

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        value_next   = value_reg;
        addr_next    = addr_reg;
        d_next       = d_reg;
        res_next     = res_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;

        wr_en   = 1'b0;
        wr_addr = count_reg[ADDR_W-1:0];
        wr_data = s_data.value;
        rd_en   = 1'b0;
        rd_addr = top_wide[ADDR_W-1:0];

        // drop the result once the sink takes it
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    res_next   = '0;
                    value_next = s_data.value;
                    state_next = ST_EMIT;
                    unique case (s_data.func)
                        OP_PUSH: begin
                            // store on top unless full
                            if (count_reg < CNT_W'(DEPTH)) begin
                                wr_en       = 1'b1;
                                count_next  = count_reg + CNT_W'(1);
                                res_next.ok = 1'b1;
                            end
                        end
                        OP_POP: begin
                            if (count_reg != '0) begin
                                rd_en      = 1'b1;
                                count_next = count_reg - CNT_W'(1);
                                state_next = ST_READ;
                            end
                        end
                        OP_FIND: begin
                            // start the scan at the top word
                            if (count_reg != '0) begin
                                rd_en      = 1'b1;
                                addr_next  = top_wide[ADDR_W-1:0];
                                d_next     = '0;
                                state_next = ST_SCAN;
                            end
                        end
                        OP_READ: begin
                            if (pos_wide < cnt_wide) begin
                                rd_en      = 1'b1;
                                rd_addr    = rd_at_wide[ADDR_W-1:0];
                                state_next = ST_READ;
                            end
                        end
                        default: begin
                            res_next = '0;
                        end
                    endcase
                end
            end
            ST_READ: begin
                res_next.ok       = 1'b1;
                res_next.data_out = rd_data;
                state_next        = ST_EMIT;
            end
            ST_SCAN: begin
                if (rd_data == value_reg) begin
                    res_next.ok             = 1'b1;
                    res_next.data_out       = value_reg;
                    res_next.found_position = d_wide[POS_W-1:0];
                    state_next              = ST_EMIT;
                end else if (scan_last) begin
                    state_next = ST_EMIT;
                end else begin
                    // advance one word toward the bottom
                    rd_en     = 1'b1;
                    rd_addr   = addr_reg - ADDR_W'(1);
                    addr_next = addr_reg - ADDR_W'(1);
                    d_next    = d_reg + ADDR_W'(1);
                end
            end
            ST_EMIT: begin
                // hold until the output register can take the result
                if (out_free) begin
                    m_data_next           = res_reg;
                    m_data_next.depth_now = cnt_wide[DEPTH_NOW_W-1:0];
                    m_data_next.is_empty  = (count_reg == '0);
                    m_valid_next          = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        value_reg  <= value_next;
        addr_reg   <= addr_next;
        d_reg      <= d_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

endmodule

/* design/lss_chk.sv */
// ----------------------------------------------------------------------------
// LIFO stack with search: port checker
// Concurrent checks on the top level's ports, bound to the top level.
// ----------------------------------------------------------------------------
module lss_chk (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input lss_pkg::out_t m_data
);
    import lss_pkg::*;

    // no result survives reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // one item at a time: the input closes after a transfer
    a_in_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input stayed open after a transfer");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // empty flag only with a zero count
    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.is_empty |-> m_data.depth_now == '0)
        else $error("empty flag with nonzero count");

    // failed operations return zero data and position
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.ok |-> m_data.data_out == '0 && m_data.found_position == '0)
        else $error("failed operation returned data");

endmodule

bind lifo_stack_with_search_top lss_chk u_lss_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

/* bench/lifo_stack_with_search_top_test.sv */
// ----------------------------------------------------------------------------
// LIFO stack with search: block-level test
// Drives push, pop, find-value and read-at-position transfers into the stack
// and checks every result against a behavioral stack model kept in the bench.
// A short table of hand-picked cases comes first, then a long random run that
// repeatedly fills the stack past full and drains it past empty, with random
// gaps on the input side and random back-pressure on the result side.
// ----------------------------------------------------------------------------
module lifo_stack_with_search_top_test;

    import lss_pkg::*;

    // longest stretch with no transfer on either channel before giving up;
    // it must cover a find that misses on a full stack
    localparam int STALL_LIMIT  = 40 * DEPTH + 2000;
    // settle time after the last result, covers a full-depth find
    localparam int SETTLE_CYCLES = DEPTH + 16;
    localparam int RANDOM_ITEMS  = 525;
    // random items with no idling on either side
    localparam int QUIET_FIRST   = 200;
    localparam int QUIET_LAST    = 320;

    typedef struct {
        in_t  item;
        bit   typed;    // expected result written in the table
        out_t result;
    } directed_case_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    // bench-side copy of the stack
    logic signed [WORD_W-1:0] stack_words [DEPTH];
    int unsigned              stack_count = 0;

    out_t           expected_results [$];
    directed_case_t directed_cases   [$];
    out_t           oldest_result;
    int             mismatch_count = 0;
    int             stall_cycles   = 0;
    bit             quiet          = 1'b0;
    bit             filling        = 1'b1;

    lifo_stack_with_search_top uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Apply one operation to the bench stack and return the result the block
    // must produce for it.
    function automatic out_t predict_stack_result(input in_t item);
        out_t        res;
        int unsigned d;
        res = '0;
        case (item.func)
            OP_PUSH: begin
                if (stack_count < DEPTH) begin
                    stack_words[stack_count] = item.value;
                    stack_count++;
                    res.ok = 1'b1;
                end
            end
            OP_POP: begin
                if (stack_count > 0) begin
                    stack_count--;
                    res.data_out = stack_words[stack_count];
                    res.ok       = 1'b1;
                end
            end
            OP_FIND: begin
                // nearest match wins: scan from the top down
                for (d = 0; d < stack_count && !res.ok; d++) begin
                    if (stack_words[stack_count - 1 - d] == item.value) begin
                        res.ok             = 1'b1;
                        res.data_out       = item.value;
                        res.found_position = POS_W'(d);
                    end
                end
            end
            default: begin
                if (item.position_in < stack_count) begin
                    res.data_out = stack_words[stack_count - 1 - item.position_in];
                    res.ok       = 1'b1;
                end
            end
        endcase
        res.depth_now = DEPTH_NOW_W'(stack_count);
        res.is_empty  = (stack_count == 0);
        return res;
    endfunction

    // Append a row to the directed table. With typed clear the expected
    // fields are ignored and the stack model supplies the result.
    function automatic void add_directed_case(
        input logic [FUNC_W-1:0]        func,
        input logic signed [WORD_W-1:0] value,
        input logic [POS_W-1:0]         position_in,
        input bit                       typed,
        input logic                     ok,
        input logic signed [WORD_W-1:0] data_out,
        input logic [POS_W-1:0]         found_position,
        input logic [DEPTH_NOW_W-1:0]   depth_now
    );
        directed_case_t row;
        row.item.func              = func;
        row.item.value             = value;
        row.item.position_in       = position_in;
        row.typed                  = typed;
        row.result.ok              = ok;
        row.result.data_out        = data_out;
        row.result.found_position  = found_position;
        row.result.depth_now       = depth_now;
        row.result.is_empty        = (depth_now == 0);
        directed_cases.push_back(row);
    endfunction

    // Build one random operation. The mix leans toward push while filling and
    // toward pop while draining, so the stack swings between full and empty
    // and both overflow and underflow attempts show up.
    function automatic in_t next_random_item();
        in_t         item;
        int unsigned pick;
        pick = $urandom_range(99);
        if (filling) begin
            item.func = (pick < 62) ? OP_PUSH : (pick < 72) ? OP_POP :
                        (pick < 87) ? OP_FIND : OP_READ;
        end else begin
            item.func = (pick < 62) ? OP_POP : (pick < 72) ? OP_PUSH :
                        (pick < 87) ? OP_FIND : OP_READ;
        end
        case ($urandom_range(3))
            0:       item.value = $urandom;
            1:       item.value = $signed($urandom_range(7)) - 4;  // force duplicates
            2: begin
                case ($urandom_range(3))
                    0:       item.value = 32'sh7FFF_FFFF;
                    1:       item.value = 32'sh8000_0000;
                    2:       item.value = '0;
                    default: item.value = -1;
                endcase
            end
            default: item.value = $urandom;
        endcase
        // make most finds hit something that is held
        if (item.func == OP_FIND && stack_count > 0 && $urandom_range(99) < 65) begin
            item.value = stack_words[$urandom_range(stack_count - 1)];
        end
        item.position_in = POS_W'($urandom_range(63));
        if (item.func == OP_READ && stack_count > 0 && $urandom_range(99) < 70) begin
            item.position_in = POS_W'($urandom_range(stack_count - 1));
        end
        // turn around a while after hitting either end
        if (filling && stack_count == DEPTH && $urandom_range(3) == 0) begin
            filling = 1'b0;
        end else if (!filling && stack_count == 0 && $urandom_range(3) == 0) begin
            filling = 1'b1;
        end
        return item;
    endfunction

    // Drive one operation until it transfers, then record what must come back.
    // Entered right after a rising edge, so every assignment here lands on
    // that edge's step.
    task automatic send_operation(input in_t item, input bit typed, input out_t typed_result);
        out_t predicted;
        // insert random gaps ahead of the transfer
        while (!quiet && $urandom_range(99) < 6) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_data  <= item;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // advance the model even for typed rows so later rows see the right stack
        predicted = predict_stack_result(item);
        expected_results.push_back(typed ? typed_result : predicted);
    endtask

    // Result side: check every transfer against the oldest expectation, then
    // pick the ready value for the next cycle.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing expected: depth_now %0d",
                       m_data.depth_now);
                mismatch_count++;
            end else begin
                oldest_result = expected_results.pop_front();
                if (m_data.ok !== oldest_result.ok) begin
                    $error("ok: expected %0b, got %0b", oldest_result.ok, m_data.ok);
                    mismatch_count++;
                end
                if (m_data.data_out !== oldest_result.data_out) begin
                    $error("data_out: expected %0d, got %0d",
                           oldest_result.data_out, m_data.data_out);
                    mismatch_count++;
                end
                if (m_data.found_position !== oldest_result.found_position) begin
                    $error("found_position: expected %0d, got %0d",
                           oldest_result.found_position, m_data.found_position);
                    mismatch_count++;
                end
                if (m_data.depth_now !== oldest_result.depth_now) begin
                    $error("depth_now: expected %0d, got %0d",
                           oldest_result.depth_now, m_data.depth_now);
                    mismatch_count++;
                end
                if (m_data.is_empty !== oldest_result.is_empty) begin
                    $error("is_empty: expected %0b, got %0b",
                           oldest_result.is_empty, m_data.is_empty);
                    mismatch_count++;
                end
            end
        end
        // stall the result side now and then, never during the quiet stretch
        m_ready <= quiet || ($urandom_range(99) >= 6);
    end

    // Watchdog: end the run if neither channel moves a transfer for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("lifo_stack_with_search_top test failed");
            $finish;
        end
    end

    initial begin
        int i;
        // Directed table: empty-stack failures, extreme words, a duplicate so
        // the find must report the nearest copy, a find miss, reads at both
        // ends and past the held words, then pops back down to empty.
        add_directed_case(OP_POP,  32'sh1234_5678, 6'd0,  1, 1'b0, '0, 6'd0, 7'd0);
        add_directed_case(OP_READ, 32'sh0,         6'd0,  1, 1'b0, '0, 6'd0, 7'd0);
        add_directed_case(OP_FIND, 32'sh0,         6'd63, 1, 1'b0, '0, 6'd0, 7'd0);
        add_directed_case(OP_PUSH, 32'sh7FFF_FFFF, 6'd63, 1, 1'b1, '0, 6'd0, 7'd1);
        add_directed_case(OP_PUSH, 32'sh8000_0000, 6'd0,  1, 1'b1, '0, 6'd0, 7'd2);
        add_directed_case(OP_PUSH, 32'sh0,         6'd21, 1, 1'b1, '0, 6'd0, 7'd3);
        add_directed_case(OP_PUSH, -32'sd1,        6'd42, 1, 1'b1, '0, 6'd0, 7'd4);
        add_directed_case(OP_PUSH, 32'sh7FFF_FFFF, 6'd0,  1, 1'b1, '0, 6'd0, 7'd5);
        add_directed_case(OP_FIND, 32'sh7FFF_FFFF, 6'd63, 1, 1'b1, 32'sh7FFF_FFFF, 6'd0, 7'd5);
        add_directed_case(OP_FIND, 32'sh8000_0000, 6'd0,  1, 1'b1, 32'sh8000_0000, 6'd3, 7'd5);
        add_directed_case(OP_FIND, -32'sd1,        6'd0,  1, 1'b1, -32'sd1, 6'd1, 7'd5);
        add_directed_case(OP_FIND, 32'sd12345,     6'd0,  1, 1'b0, '0, 6'd0, 7'd5);
        add_directed_case(OP_READ, -32'sd1,        6'd0,  1, 1'b1, 32'sh7FFF_FFFF, 6'd0, 7'd5);
        add_directed_case(OP_READ, 32'sh0,         6'd4,  1, 1'b1, 32'sh7FFF_FFFF, 6'd0, 7'd5);
        add_directed_case(OP_READ, 32'sh0,         6'd3,  1, 1'b1, 32'sh8000_0000, 6'd0, 7'd5);
        add_directed_case(OP_READ, 32'sh0,         6'd5,  1, 1'b0, '0, 6'd0, 7'd5);
        add_directed_case(OP_READ, 32'sh7FFF_FFFF, 6'd63, 1, 1'b0, '0, 6'd0, 7'd5);
        add_directed_case(OP_POP,  -32'sd1,        6'd63, 1, 1'b1, 32'sh7FFF_FFFF, 6'd0, 7'd4);
        add_directed_case(OP_POP,  32'sh0,         6'd0,  1, 1'b1, -32'sd1, 6'd0, 7'd3);
        add_directed_case(OP_FIND, 32'sh7FFF_FFFF, 6'd0,  1, 1'b1, 32'sh7FFF_FFFF, 6'd2, 7'd3);
        add_directed_case(OP_PUSH, 32'sd55,        6'd63, 0, 1'b0, '0, 6'd0, 7'd0);
        add_directed_case(OP_POP,  32'sh0,         6'd0,  0, 1'b0, '0, 6'd0, 7'd0);
        add_directed_case(OP_POP,  32'sh0,         6'd0,  0, 1'b0, '0, 6'd0, 7'd0);
        add_directed_case(OP_POP,  32'sh0,         6'd0,  0, 1'b0, '0, 6'd0, 7'd0);
        add_directed_case(OP_POP,  32'sh0,         6'd0,  0, 1'b0, '0, 6'd0, 7'd0);

        // hold reset, then release it on an edge
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_cases[k]) begin
            send_operation(directed_cases[k].item, directed_cases[k].typed,
                           directed_cases[k].result);
        end

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            quiet = (i >= QUIET_FIRST && i < QUIET_LAST);
            send_operation(next_random_item(), 1'b0, '0);
        end
        quiet = 1'b0;
        s_valid <= 1'b0;

        // wait out every result, then give a late extra result time to show up
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("lifo_stack_with_search_top test passed");
        end else begin
            $display("lifo_stack_with_search_top test failed");
        end
        $finish;
    end

endmodule
